// ===== src/dlefd_pkg.sv =====
package dlefd_pkg;

	localparam int FRAME_MAX = 64;
	localparam int IDX_W     = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
	localparam int CNT_W     = $clog2(FRAME_MAX + 1);
	localparam int BYTE_W    = 8;
	localparam int BIDX_W    = 6;
	localparam int FLEN_W    = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END    = 1'd1;

	localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd16;
	localparam logic [BYTE_W-1:0] END_RST    = 8'd3;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} rd_req_t;

endpackage

// ===== src/dle_etx_frame_deframer.sv =====
// dle/etx deframer: one raw link byte per input transfer on rx_byte
// (in_valid/in_ready). doubled escape bytes are stored once, escape then
// end code closes the frame, any other byte is stored as it stands.
// a byte that does not close a frame gives no result; in_ready stays high
// so bytes may arrive back to back.
// a closing byte starts playback: the frame store is read one entry at a
// time through its single registered read port; for each entry the block
// passes through ST_READ, where the read is issued, and then ST_SHOW, where
// the result is offered. in_ready stays low for the whole playback; an empty
// frame gives one result flagged empty_frame.
// a stalled out_ready simply holds the current result and the playback.
// escape_code and end_code are written through cfg_valid/cfg_index/cfg_data;
// the user must do so only while the block is idle, the block does not enforce
// it; cfg_ready is always high. reset (arst_n low) sets escape_code to 16,
// end_code to 3 and clears the pending escape and fill count; store contents
// are not cleared since only written entries are ever played back.
module dle_etx_frame_deframer
	import dlefd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    frame_byte,
	output logic [BIDX_W-1:0]    byte_index,
	output logic [FLEN_W-1:0]    frame_length,
	output logic                 empty_frame,
	output logic                 last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_SHOW = 2'd2;

	logic [1:0]        state_q;
	logic [BYTE_W-1:0] esc_q;
	logic [BYTE_W-1:0] end_q;
	logic              pend_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  len_q;
	logic [IDX_W-1:0]  idx_q;

	logic              in_fire;
	logic              out_fire;
	logic              is_esc;
	logic              is_end;
	logic              full;
	logic              first_esc;
	logic              frame_end;
	logic              do_store;
	logic              is_last;
	wr_req_t           wr;
	rd_req_t           rd;
	logic [BYTE_W-1:0] rd_data;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SHOW);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	assign is_esc    = (rx_byte == esc_q);
	assign is_end    = (rx_byte == end_q);
	assign full      = (fill_q >= CNT_W'(FRAME_MAX));
	assign first_esc = is_esc && !pend_q;
	// escape meaning wins when both codes match
	assign frame_end = !is_esc && is_end && pend_q;
	assign do_store  = !first_esc && !frame_end && !full;

	assign wr.en   = in_fire && do_store;
	assign wr.addr = fill_q[IDX_W-1:0];
	assign wr.data = rx_byte;
	assign rd.en   = (state_q == ST_READ);
	assign rd.addr = idx_q;

	dlefd_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= ESCAPE_RST;
			end_q <= END_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ESCAPE: esc_q <= cfg_data;
				CFG_END:    end_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
			fill_q  <= '0;
			len_q   <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						priority if (first_esc) begin
							pend_q <= 1'b1;
						end else if (frame_end) begin
							pend_q  <= 1'b0;
							fill_q  <= '0;
							len_q   <= fill_q;
							idx_q   <= '0;
							state_q <= ST_READ;
						end else if (full) begin
							// overrun: drop the partial frame and this byte
							pend_q <= 1'b0;
							fill_q <= '0;
						end else begin
							pend_q <= 1'b0;
							fill_q <= fill_q + CNT_W'(1);
						end
					end
				end
				ST_READ: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (out_fire) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty_frame  = (len_q == '0);
	assign is_last      = empty_frame || (CNT_W'(idx_q) + CNT_W'(1) == len_q);
	assign last         = is_last;
	assign frame_byte   = empty_frame ? '0 : rd_data;
	assign byte_index   = BIDX_W'(idx_q);
	assign frame_length = FLEN_W'(len_q);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(FRAME_MAX))
		else $error("fill count beyond store depth");

	a_no_input_in_playback: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken during playback");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && frame_end) |-> ##2 out_valid)
		else $error("frame end did not start playback");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last) |=> in_ready)
		else $error("playback did not end after last transfer");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_frame) |-> (last && byte_index == '0))
		else $error("empty frame result malformed");

endmodule

// ===== src/dlefd_store.sv =====
module dlefd_store
	import dlefd_pkg::*;
(
	input  logic              clk,
	input  wr_req_t           wr,
	input  rd_req_t           rd,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [FRAME_MAX];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== test/tb_dle_etx_frame_deframer.sv =====
`timescale 1ns / 100ps

module tb_dle_etx_frame_deframer;
	import dlefd_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int PHASE_ITEMS = 12;
	localparam int PRINT_CAP   = 30;

	typedef enum int {TAIL_CLOSE, TAIL_BROKEN, TAIL_OPEN} frame_tail_t;

	typedef struct packed {
		logic [BYTE_W-1:0] fbyte;
		logic [BIDX_W-1:0] idx;
		logic [FLEN_W-1:0] len;
		logic              empty;
		logic              fin;
	} frame_item_t;

	class frame_scoreboard_t;
		logic [BYTE_W-1:0] escape_code;
		logic [BYTE_W-1:0] end_code;
		bit                esc_pending;
		int                fill;
		logic [BYTE_W-1:0] store [FRAME_MAX];
		frame_item_t       expected_q [$];
		int errors, results_seen, bytes_taken, frames_closed, empty_frames, discards;

		function void reset_state();
			escape_code = ESCAPE_RST;
			end_code    = END_RST;
			esc_pending = 1'b0;
			fill        = 0;
			expected_q.delete();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
			if (idx == CFG_ESCAPE) begin
				escape_code = val;
			end else if (idx == CFG_END) begin
				end_code = val;
			end
		endfunction

		function void drop_frame();
			esc_pending = 1'b0;
			fill        = 0;
			discards++;
		endfunction

		function void keep_byte(logic [BYTE_W-1:0] b);
			store[fill] = b;
			fill++;
			esc_pending = 1'b0;
		endfunction

		function void play_frame();
			frame_item_t it;
			frames_closed++;
			if (fill == 0) begin
				empty_frames++;
				it = '{fbyte: '0, idx: '0, len: '0, empty: 1'b1, fin: 1'b1};
				expected_q.push_back(it);
			end else begin
				for (int k = 0; k < fill; k++) begin
					it.fbyte = store[k];
					it.idx   = BIDX_W'(k);
					it.len   = FLEN_W'(fill);
					it.empty = 1'b0;
					it.fin   = (k == fill - 1);
					expected_q.push_back(it);
				end
			end
		endfunction

		// called once per accepted link byte
		function void note_byte(logic [BYTE_W-1:0] b);
			bytes_taken++;
			if (b == escape_code) begin
				if (!esc_pending) begin
					esc_pending = 1'b1;
				end else if (fill >= FRAME_MAX) begin
					drop_frame();
				end else begin
					keep_byte(b);
				end
			end else if (b == end_code && esc_pending) begin
				play_frame();
				esc_pending = 1'b0;
				fill        = 0;
			end else if (fill >= FRAME_MAX) begin
				drop_frame();
			end else begin
				keep_byte(b);
			end
		endfunction

		task report_mismatch(string msg);
			errors++;
			// keep the log short on a badly broken block
			if (errors <= PRINT_CAP) begin
				$display("mismatch at %0t: %s", $time, msg);
			end
		endtask

		task check_result(frame_item_t got);
			frame_item_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %02h index %0d",
					got.fbyte, got.idx));
				return;
			end
			want = expected_q.pop_front();
			if (got.fbyte !== want.fbyte)
				report_mismatch($sformatf("frame_byte %02h, want %02h", got.fbyte, want.fbyte));
			if (got.idx !== want.idx)
				report_mismatch($sformatf("byte_index %0d, want %0d", got.idx, want.idx));
			if (got.len !== want.len)
				report_mismatch($sformatf("frame_length %0d, want %0d", got.len, want.len));
			if (got.empty !== want.empty)
				report_mismatch($sformatf("empty_frame %b, want %b", got.empty, want.empty));
			if (got.fin !== want.fin)
				report_mismatch($sformatf("last %b, want %b", got.fin, want.fin));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ESCAPE;
	logic [BYTE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [BYTE_W-1:0]    frame_byte;
	logic [BIDX_W-1:0]    byte_index;
	logic [FLEN_W-1:0]    frame_length;
	logic                 empty_frame;
	logic                 last;

	frame_scoreboard_t sb = new();
	int gap_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	dle_etx_frame_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.byte_index   (byte_index),
		.frame_length (frame_length),
		.empty_frame  (empty_frame),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.expected_q.size());
			$display("FAIL dle_etx_frame_deframer");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(frame_item_t'{fbyte: frame_byte, idx: byte_index,
				len: frame_length, empty: empty_frame, fin: last});
		end
	end

	task automatic send_byte(logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
	endtask

	task automatic send_list(input logic [BYTE_W-1:0] seq [$]);
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(255)); while (b == sb.escape_code || b == sb.end_code);
		return b;
	endfunction

	// content leans towards the two code values so stuffing and raw end codes are common
	function automatic logic [BYTE_W-1:0] content_byte(int pos);
		logic [BYTE_W-1:0] b;
		int r;
		r = $urandom_range(99);
		if (r < 12) b = sb.escape_code;
		else if (r < 20) b = sb.end_code;
		else b = BYTE_W'($urandom_range(255));
		// the id byte after the opening escape is never a code value
		if (pos == 0 && (b == sb.end_code || b == sb.escape_code)) b = plain_byte();
		return b;
	endfunction

	task automatic send_frame(int n, frame_tail_t tail);
		logic [BYTE_W-1:0] b;
		if (sb.esc_pending) send_byte(plain_byte());
		send_byte(sb.escape_code);
		for (int k = 0; k < n; k++) begin
			b = content_byte(k);
			if (b == sb.escape_code) send_byte(b);
			send_byte(b);
		end
		case (tail)
			TAIL_CLOSE: begin
				// an empty frame is just the opening escape and the end code
				if (n > 0) send_byte(sb.escape_code);
				send_byte(sb.end_code);
			end
			TAIL_BROKEN: begin
				send_byte(sb.escape_code);
				send_byte(plain_byte());
			end
			default: ;
		endcase
	endtask

	task automatic set_codes(logic [BYTE_W-1:0] esc, logic [BYTE_W-1:0] fin);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ESCAPE;
		cfg_data  <= esc;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(CFG_ESCAPE, esc);
		cfg_index <= CFG_END;
		cfg_data  <= fin;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(CFG_END, fin);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		// a closing byte starts playback only after it has been taken
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int p;
		int start;
		int r;
		logic [BYTE_W-1:0] e;
		logic [BYTE_W-1:0] t;

		sb.reset_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset codes: stuffed escape, raw end code, empty frame, bytes with no opening escape
		send_list('{ESCAPE_RST, 8'h8F, 8'h00, 8'hFF, ESCAPE_RST, ESCAPE_RST, END_RST,
			8'h80, 8'h7F, ESCAPE_RST, END_RST});
		send_list('{ESCAPE_RST, END_RST});
		send_list('{END_RST, 8'h55, ESCAPE_RST, END_RST});
		wait_idle();
		set_codes(8'h00, 8'hFF);
		send_list('{8'h00, 8'h01, 8'hFF, 8'h00, 8'hFF});
		wait_idle();
		// equal codes: escape wins, nothing ever closes
		set_codes(8'h42, 8'h42);
		send_list('{8'h42, 8'h42, 8'h42, 8'h42});
		wait_idle();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: set_codes(ESCAPE_RST, END_RST);
				1: set_codes(8'hFF, 8'h00);
				4: begin
					e = BYTE_W'($urandom_range(255));
					set_codes(e, e);
				end
				default: begin
					e = BYTE_W'($urandom_range(255));
					do t = BYTE_W'($urandom_range(255)); while (t == e);
					set_codes(e, t);
				end
			endcase
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 51; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 51; end
				default: begin gap_pct = 33; stall_pct = 33; end
			endcase
			start = sb.bytes_taken;

			// full store: exact fit, then overrun by a data byte and by a doubled escape
			if (p == 0) begin
				send_frame(0, TAIL_CLOSE);
				send_frame(FRAME_MAX, TAIL_CLOSE);
			end else if (p == 1) begin
				send_frame(0, TAIL_CLOSE);
				send_frame(FRAME_MAX, TAIL_OPEN);
				send_byte(plain_byte());
				send_frame(0, TAIL_CLOSE);
			end else if (p == 2) begin
				send_frame(0, TAIL_CLOSE);
				send_frame(FRAME_MAX, TAIL_OPEN);
				send_byte(sb.escape_code);
				send_byte(sb.escape_code);
				send_frame(0, TAIL_CLOSE);
			end

			while (sb.bytes_taken - start < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 10) send_frame(0, TAIL_CLOSE);
				else if (r < 20) repeat ($urandom_range(1, 4))
					send_byte(BYTE_W'($urandom_range(255)));
				else if (r < 28) send_frame($urandom_range(1, 6), TAIL_BROKEN);
				else if (r < 31) send_frame($urandom_range(20, FRAME_MAX), TAIL_CLOSE);
				else send_frame($urandom_range(1, 10), TAIL_CLOSE);
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		$display("sent %0d link bytes under eight code settings and four idling patterns",
			sb.bytes_taken);
		$display("%0d frames closed (%0d empty), %0d overrun discards, %0d results checked",
			sb.frames_closed, sb.empty_frames, sb.discards, sb.results_seen);
		if (sb.errors == 0) begin
			$display("PASS dle_etx_frame_deframer");
		end else begin
			$display("FAIL dle_etx_frame_deframer");
		end
		$finish;
	end

endmodule
